// File: design/mbu_pkg.sv
// Package for the modular binomial unit: prime constants, command codes,
// datapath select codes and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package mbu_pkg;

  localparam int unsigned VW = 30;  // residue width

  localparam logic [VW-1:0] PRIME   = 30'd998244353;
  localparam logic [30:0]   PRIME_X = 31'd998244353;
  localparam logic [30:0]   PRIME_2X = 31'd1996488706;
  // Fermat inverse exponent, p - 2
  localparam logic [30:0]   INV_EXP = 31'd998244351;
  // Barrett constant floor(2^60 / p)
  localparam logic [63:0]   MU_W = 64'h1000_0000_0000_0000 / 64'd998244353;
  localparam logic [30:0]   MU = MU_W[30:0];

  typedef enum logic [1:0] {
    CMD_POW  = 2'd0,
    CMD_COMB = 2'd1,
    CMD_PERM = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    A_HOLD, A_ONE, A_ZERO, A_RD, A_MUL
  } a_sel_e;

  typedef enum logic [1:0] {
    B_HOLD, B_BASE, B_ACC, B_MUL
  } b_sel_e;

  typedef enum logic [1:0] {
    E_HOLD, E_EXP, E_INV, E_SHR
  } e_sel_e;

  typedef enum logic [2:0] {
    M_A_B, M_B_B, M_A_IDX, M_A_RD, M_N_A
  } mul_sel_e;

  typedef enum logic [1:0] {
    RD_TOP, RD_DIFF, RD_CHOOSE
  } rd_sel_e;

  typedef struct packed {
    logic     ld_item;
    a_sel_e   a_sel;
    b_sel_e   b_sel;
    e_sel_e   e_sel;
    logic     n_ld;
    rd_sel_e  rd_sel;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     idx_clr;
    logic     idx_inc;
    logic     fill_wr;
    logic     out_ld;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic top_oor;
    logic r_bad;
    logic e_zero;
    logic e_lsb;
    logic mul_done;
    logic fill_last;
  } dp_status_t;

endpackage

`default_nettype wire

// File: design/modular_binomial_unit.sv
// Operation: a power does one squaring per exponent bit plus one product per set bit;
//   C/P items take table reads and products plus a 30-bit Fermat inverse.
// Throughput: one item at a time; the 5-stage shared modular multiplier sets the pace.
// Reset: asynchronous, active low; afterwards the factorial table fills, one entry at a
//   time, and no item is accepted until it completes.
`default_nettype none

module modular_binomial_unit
  import mbu_pkg::*;
#(
  parameter int TABLE_DEPTH = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // command[1:0], base[32:2], exponent[63:33], top[75:64], choose[88:76], zero fill
  input  wire logic [95:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // value[29:0], out_of_range[30], zero fill
  output logic [31:0]      m_axis_tdata_o
);

  dp_cmd_t       dp_cmd;
  dp_status_t    dp_status;
  logic [VW-1:0] value;
  logic          oor;

  // Controller: sequences fill, table reads and square-and-multiply steps.
  mbu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  // Datapath: operand registers, factorial memory and the shared multiplier.
  mbu_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (dp_cmd),
    .status_o (dp_status),
    .item_i   (s_axis_tdata_i[88:0]),
    .value_o  (value),
    .oor_o    (oor)
  );

  // Result transfer: value in the low bits, range flag above it.
  assign m_axis_tdata_o = {1'b0, oor, value};

`ifndef SYNTH
  // Every delivered value is a proper residue.
  a_value_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[29:0] < PRIME))
    else $error("result value not reduced mod p");

  // An out-of-range result always carries a zero value.
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[30]) |-> (m_axis_tdata_o[29:0] == '0))
    else $error("out-of-range result with nonzero value");

  // No new item is taken in the cycle after one was accepted.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("second item accepted while one is in flight");
`endif

endmodule

`default_nettype wire

// File: design/mbu_mulmod.sv
// Pipelined modular multiplier mod 998244353 using Barrett reduction.
// Five register stages; depends on mbu_pkg.
`default_nettype none

module mbu_mulmod
  import mbu_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [VW-1:0] op_a_i,
  input  wire logic [VW-1:0] op_b_i,
  output logic               done_o,
  output logic [VW-1:0]      res_o
);

  logic [4:0]  vld_q;
  logic [59:0] prod_q;
  logic [61:0] q2_q;
  logic [31:0] xlo2_q, xlo3_q;
  logic [31:0] qp_q;
  logic [31:0] r_q;
  logic [VW-1:0] res_q;
  logic [61:0] qp_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], start_i};
    end
  end

  assign qp_full = 62'(q2_q[61:31]) * 62'(PRIME);

  always_ff @(posedge clk_i) begin
    prod_q <= 60'(op_a_i) * 60'(op_b_i);
    q2_q   <= 62'(prod_q[59:29]) * 62'(MU);
    xlo2_q <= prod_q[31:0];
    qp_q   <= qp_full[31:0];
    xlo3_q <= xlo2_q;
    r_q    <= xlo3_q - qp_q;
    // remainder is below 3p; fold it down
    if (r_q >= 32'(PRIME_2X)) begin
      res_q <= VW'(r_q - 32'(PRIME_2X));
    end else if (r_q >= 32'(PRIME)) begin
      res_q <= VW'(r_q - 32'(PRIME));
    end else begin
      res_q <= VW'(r_q);
    end
  end

  assign done_o = vld_q[4];
  assign res_o  = res_q;

endmodule

`default_nettype wire

// File: design/mbu_datapath.sv
// Datapath: item registers, accumulator/base/exponent, factorial memory,
// shared modular multiplier and output register. Depends on mbu_pkg, mbu_mulmod.
`default_nettype none

module mbu_datapath
  import mbu_pkg::*;
#(
  parameter int TABLE_DEPTH = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dp_cmd_t     cmd_i,
  output dp_status_t       status_o,
  input  wire logic [88:0] item_i,
  output logic [VW-1:0]    value_o,
  output logic             oor_o
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [1:0]    cmd_q;
  logic [11:0]   top_q;
  logic [12:0]   r_q;
  logic [30:0]   base_q;
  logic [30:0]   exp_in_q;
  logic          oor_q;
  logic [VW-1:0] a_q, b_q, n_q;
  logic [30:0]   e_q;
  logic [AW-1:0] idx_q;
  logic [VW-1:0] mem_q [TABLE_DEPTH];
  logic [VW-1:0] rd_q;
  logic [AW-1:0] rd_addr;
  logic [11:0]   diff;
  logic [VW-1:0] base_red;
  logic [VW-1:0] mul_a, mul_b, mul_res, idx_op;
  logic          mul_done;
  logic [VW-1:0] val_q;
  logic          oor_out_q;
  logic          top_oor;

  assign top_oor = 32'(top_q) >= 32'(TABLE_DEPTH);
  assign diff    = top_q - r_q[11:0];

  always_comb begin
    if (base_q >= PRIME_2X) begin
      base_red = VW'(base_q - PRIME_2X);
    end else if (base_q >= PRIME_X) begin
      base_red = VW'(base_q - PRIME_X);
    end else begin
      base_red = VW'(base_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_item) begin
      cmd_q    <= item_i[1:0];
      base_q   <= item_i[32:2];
      exp_in_q <= item_i[63:33];
      top_q    <= item_i[75:64];
      r_q      <= item_i[88:76];
      oor_q    <= (item_i[1:0] == CMD_COMB || item_i[1:0] == CMD_PERM) &&
                  (32'(item_i[75:64]) >= 32'(TABLE_DEPTH));
    end
    unique case (cmd_i.a_sel)
      A_HOLD: a_q <= a_q;
      A_ONE:  a_q <= VW'(1);
      A_ZERO: a_q <= '0;
      A_RD:   a_q <= rd_q;
      A_MUL:  a_q <= mul_res;
      default: a_q <= a_q;
    endcase
    unique case (cmd_i.b_sel)
      B_HOLD: b_q <= b_q;
      B_BASE: b_q <= base_red;
      B_ACC:  b_q <= a_q;
      B_MUL:  b_q <= mul_res;
      default: b_q <= b_q;
    endcase
    unique case (cmd_i.e_sel)
      E_HOLD: e_q <= e_q;
      E_EXP:  e_q <= exp_in_q;
      E_INV:  e_q <= INV_EXP;
      E_SHR:  e_q <= e_q >> 1;
      default: e_q <= e_q;
    endcase
    if (cmd_i.n_ld) begin
      n_q <= rd_q;
    end
    if (cmd_i.out_ld) begin
      val_q     <= a_q;
      oor_out_q <= oor_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + AW'(1);
    end
  end

  // factorial memory: one write port, one registered read port
  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_TOP:    rd_addr = AW'(top_q);
      RD_DIFF:   rd_addr = AW'(diff);
      RD_CHOOSE: rd_addr = AW'(r_q[11:0]);
      default:   rd_addr = AW'(top_q);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_wr) begin
      mem_q[idx_q] <= mul_res;
    end
    rd_q <= mem_q[rd_addr];
  end

  assign idx_op = (idx_q == '0) ? VW'(1) : VW'(idx_q);

  always_comb begin
    unique case (cmd_i.mul_sel)
      M_A_B:   begin mul_a = a_q; mul_b = b_q;    end
      M_B_B:   begin mul_a = b_q; mul_b = b_q;    end
      M_A_IDX: begin mul_a = a_q; mul_b = idx_op; end
      M_A_RD:  begin mul_a = a_q; mul_b = rd_q;   end
      M_N_A:   begin mul_a = n_q; mul_b = a_q;    end
      default: begin mul_a = a_q; mul_b = b_q;    end
    endcase
  end

  mbu_mulmod u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .op_a_i  (mul_a),
    .op_b_i  (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  assign status_o.cmd       = cmd_e'(cmd_q);
  assign status_o.top_oor   = top_oor;
  assign status_o.r_bad     = r_q[12] || (r_q[11:0] > top_q);
  assign status_o.e_zero    = (e_q == '0);
  assign status_o.e_lsb     = e_q[0];
  assign status_o.mul_done  = mul_done;
  assign status_o.fill_last = (idx_q == AW'(TABLE_DEPTH - 1));

  assign value_o = val_q;
  assign oor_o   = oor_out_q;

endmodule

`default_nettype wire

// File: design/mbu_ctrl.sv
// Controller state machine: table fill after reset, item dispatch,
// square-and-multiply sequencing and output handshake. Depends on mbu_pkg.
`default_nettype none

module mbu_ctrl
  import mbu_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  localparam logic [4:0] S_FILL_INIT = 5'd0;
  localparam logic [4:0] S_FILL_MUL  = 5'd1;
  localparam logic [4:0] S_FILL_WAIT = 5'd2;
  localparam logic [4:0] S_IDLE      = 5'd3;
  localparam logic [4:0] S_DISPATCH  = 5'd4;
  localparam logic [4:0] S_N_CAP     = 5'd5;
  localparam logic [4:0] S_D_CAP     = 5'd6;
  localparam logic [4:0] S_R_CAP     = 5'd7;
  localparam logic [4:0] S_R_WAIT    = 5'd8;
  localparam logic [4:0] S_INV_SETUP = 5'd9;
  localparam logic [4:0] S_POW_BIT   = 5'd10;
  localparam logic [4:0] S_POW_WA    = 5'd11;
  localparam logic [4:0] S_POW_SQ    = 5'd12;
  localparam logic [4:0] S_POW_WB    = 5'd13;
  localparam logic [4:0] S_POW_END   = 5'd14;
  localparam logic [4:0] S_FIN_WAIT  = 5'd15;
  localparam logic [4:0] S_DONE      = 5'd16;

  logic [4:0] state_q, state_d;
  logic       ovld_q, ovld_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '{ld_item: 1'b0, a_sel: A_HOLD, b_sel: B_HOLD, e_sel: E_HOLD,
               n_ld: 1'b0, rd_sel: RD_TOP, mul_start: 1'b0, mul_sel: M_A_B,
               idx_clr: 1'b0, idx_inc: 1'b0, fill_wr: 1'b0, out_ld: 1'b0};
    unique case (state_q)
      S_FILL_INIT: begin
        cmd_o.a_sel   = A_ONE;
        cmd_o.idx_clr = 1'b1;
        state_d       = S_FILL_MUL;
      end
      S_FILL_MUL: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = M_A_IDX;
        state_d         = S_FILL_WAIT;
      end
      S_FILL_WAIT: begin
        if (status_i.mul_done) begin
          cmd_o.a_sel   = A_MUL;
          cmd_o.fill_wr = 1'b1;
          if (status_i.fill_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_FILL_MUL;
          end
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_item = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status_i.cmd)
          CMD_POW: begin
            cmd_o.a_sel = A_ONE;
            cmd_o.b_sel = B_BASE;
            cmd_o.e_sel = E_EXP;
            state_d     = S_POW_BIT;
          end
          CMD_COMB, CMD_PERM: begin
            if (status_i.top_oor || status_i.r_bad) begin
              cmd_o.a_sel = A_ZERO;
              state_d     = S_DONE;
            end else begin
              cmd_o.rd_sel = RD_TOP;
              state_d      = S_N_CAP;
            end
          end
          default: begin
            cmd_o.a_sel = A_ZERO;
            state_d     = S_DONE;
          end
        endcase
      end
      S_N_CAP: begin
        cmd_o.n_ld   = 1'b1;
        cmd_o.rd_sel = RD_DIFF;
        state_d      = S_D_CAP;
      end
      S_D_CAP: begin
        cmd_o.a_sel = A_RD;
        if (status_i.cmd == CMD_COMB) begin
          cmd_o.rd_sel = RD_CHOOSE;
          state_d      = S_R_CAP;
        end else begin
          state_d = S_INV_SETUP;
        end
      end
      S_R_CAP: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = M_A_RD;
        state_d         = S_R_WAIT;
      end
      S_R_WAIT: begin
        if (status_i.mul_done) begin
          cmd_o.a_sel = A_MUL;
          state_d     = S_INV_SETUP;
        end
      end
      S_INV_SETUP: begin
        cmd_o.a_sel = A_ONE;
        cmd_o.b_sel = B_ACC;
        cmd_o.e_sel = E_INV;
        state_d     = S_POW_BIT;
      end
      S_POW_BIT: begin
        priority if (status_i.e_zero) begin
          state_d = S_POW_END;
        end else if (status_i.e_lsb) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = M_A_B;
          state_d         = S_POW_WA;
        end else begin
          state_d = S_POW_SQ;
        end
      end
      S_POW_WA: begin
        if (status_i.mul_done) begin
          cmd_o.a_sel = A_MUL;
          state_d     = S_POW_SQ;
        end
      end
      S_POW_SQ: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = M_B_B;
        state_d         = S_POW_WB;
      end
      S_POW_WB: begin
        if (status_i.mul_done) begin
          cmd_o.b_sel = B_MUL;
          cmd_o.e_sel = E_SHR;
          state_d     = S_POW_BIT;
        end
      end
      S_POW_END: begin
        if (status_i.cmd == CMD_POW) begin
          state_d = S_DONE;
        end else begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = M_N_A;
          state_d         = S_FIN_WAIT;
        end
      end
      S_FIN_WAIT: begin
        if (status_i.mul_done) begin
          cmd_o.a_sel = A_MUL;
          state_d     = S_DONE;
        end
      end
      S_DONE: begin
        if (!ovld_q || out_ready_i) begin
          cmd_o.out_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_FILL_INIT;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_ld) begin
      ovld_d = 1'b1;
    end else if (out_ready_i) begin
      ovld_d = 1'b0;
    end else begin
      ovld_d = ovld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_FILL_INIT;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovld_q;

endmodule

`default_nettype wire
